### hw/rtl/b64lw_pkg.sv
// Package for the Base64 encoder with line wrapping.
// Holds the group record type, the character constants and the alphabet lookup.
// No dependencies.
package b64lw_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgUrlAlphabet = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLineLength  = 2'd1;

  localparam logic [CharW-1:0] PadChar     = 8'h3D;
  localparam logic [CharW-1:0] NewlineChar = 8'h0A;
  localparam logic [7:0]       LineLenRst  = 8'd76;

  // One completed group of four characters waiting to be sent
  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic [3:0][CharW-1:0]     chars;
  } grp_rec_t;

  // Map a six-bit value onto the standard or URL-safe alphabet
  function automatic logic [CharW-1:0] b64_char(input logic [5:0] v, input logic url);
    logic [CharW-1:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = url ? 8'h2D : 8'h2B;
    end else begin
      c = url ? 8'h5F : 8'h2F;
    end
    return c;
  endfunction

endpackage

### hw/rtl/b64lw_group.sv
// Byte gathering stage: collects up to three bytes and codes a group.
// Depends on b64lw_pkg.
module b64lw_group import b64lw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             url_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output grp_rec_t         rec_o,
  input  logic             rec_pop_i
);

  logic [15:0] held_q, held_d;
  logic [1:0]  fill_q, fill_d;
  grp_rec_t    rec_q, rec_d;

  logic [1:0]  fill;
  logic [1:0]  nbytes_m1;
  logic [15:0] held_nx;
  logic [23:0] val;
  logic        accept, complete;

  assign in_ready_o = !rec_q.valid || rec_pop_i;
  assign accept     = in_valid_i && in_ready_o;

  // Gather bytes and build the 24-bit group word
  always_comb begin
    fill      = (fill_q == 2'd3) ? 2'd2 : fill_q;
    nbytes_m1 = fill;
    case (fill)
      2'd0:    held_nx = {in_byte_i, 8'h00};
      2'd1:    held_nx = {held_q[15:8], in_byte_i};
      default: held_nx = held_q;
    endcase
    complete = (nbytes_m1 == 2'd2) || in_last_i;
    val = {held_nx, 8'h00};
    if (nbytes_m1 == 2'd2) begin
      val[7:0] = in_byte_i;
    end
    if (nbytes_m1 == 2'd0) begin
      val[15:0] = 16'h0000;
    end
  end

  // State and record register update
  always_comb begin
    held_d = held_q;
    fill_d = fill_q;
    rec_d  = rec_q;
    if (rec_pop_i) begin
      rec_d.valid = 1'b0;
    end
    if (accept) begin
      if (complete) begin
        held_d         = 16'h0000;
        fill_d         = 2'd0;
        rec_d.valid    = 1'b1;
        rec_d.last     = in_last_i;
        rec_d.chars[0] = b64_char(val[23:18], url_i);
        rec_d.chars[1] = b64_char(val[17:12], url_i);
        rec_d.chars[2] = (nbytes_m1 != 2'd0) ? b64_char(val[11:6], url_i) : PadChar;
        rec_d.chars[3] = (nbytes_m1 == 2'd2) ? b64_char(val[5:0], url_i) : PadChar;
      end else begin
        held_d = held_nx;
        fill_d = nbytes_m1 + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      fill_q <= '0;
      rec_q  <= '0;
    end else begin
      held_q <= held_d;
      fill_q <= fill_d;
      rec_q  <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

### hw/rtl/b64lw_serial.sv
// Character serialiser: one character per cycle while output is ready, adds line breaks.
// Depends on b64lw_pkg.
module b64lw_serial import b64lw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       line_length_i,
  input  grp_rec_t         rec_i,
  output logic             rec_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] out_char_o,
  output logic             out_last_o
);

  localparam logic [1:0] StChar  = 2'd0;
  localparam logic [1:0] StNl    = 2'd1;
  localparam logic [1:0] StClose = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [1:0]       idx_q, idx_d;
  logic [7:0]       line_fill_q, line_fill_d;
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] out_char_q, out_char_d;
  logic             out_last_q, out_last_d;

  logic       load;
  logic [8:0] limit, cnt_nx;

  assign load   = (!out_valid_q || out_ready_i) && rec_i.valid;
  assign limit  = (line_length_i == 8'd0) ? 9'd256 : {1'b0, line_length_i};
  assign cnt_nx = {1'b0, line_fill_q} + 9'd1;

  // Sequencer over the four characters of a group
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    line_fill_d = line_fill_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rec_pop_o   = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b0;
      unique case (state_q)
        StChar: begin
          out_char_d = rec_i.chars[idx_q];
          if (cnt_nx >= limit) begin
            line_fill_d = 8'd0;
            state_d     = StNl;
          end else begin
            line_fill_d = cnt_nx[7:0];
            if (idx_q == 2'd3) begin
              if (rec_i.last) begin
                state_d = StClose;
              end else begin
                out_last_d = 1'b1;
                rec_pop_o  = 1'b1;
                idx_d      = 2'd0;
              end
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end
        end
        StNl: begin
          out_char_d = NewlineChar;
          state_d    = StChar;
          if (idx_q == 2'd3) begin
            out_last_d = 1'b1;
            rec_pop_o  = 1'b1;
            idx_d      = 2'd0;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
        StClose: begin
          out_char_d  = NewlineChar;
          line_fill_d = 8'd0;
          out_last_d  = 1'b1;
          rec_pop_o   = 1'b1;
          idx_d       = 2'd0;
          state_d     = StChar;
        end
        default: begin
          state_d = StChar;
          idx_d   = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StChar;
      idx_q       <= '0;
      line_fill_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      line_fill_q <= line_fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  // A group is released only with the transfer that closes it
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_pop_o |-> (load && out_last_d))
    else $error("group released without last character");

  // A pending line break always follows a counter restart
  a_nl_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StNl) |-> (line_fill_q == 8'd0))
    else $error("line break pending with non-empty line");

  // Closing newline only after the fourth character of a final group on a busy line
  a_close_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClose) |-> (rec_i.valid && rec_i.last && idx_q == 2'd3 &&
                              line_fill_q != 8'd0))
    else $error("closing newline in wrong context");

  // Index moves only when a character is loaded
  a_idx_moves_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> $stable(idx_q))
    else $error("character index changed without a load");
`endif

endmodule

### hw/rtl/base64_encoder_line_wrap_top.sv
// Base64 encoder with line wrapping: one raw byte in, ASCII characters out.
// A byte that completes a group (third byte, or flagged last) is coded
// combinationally into four characters and registered in the group record;
// the serialiser then sends one character per cycle while the output is
// ready, inserting a newline wherever a line fills and a closing newline
// after a final group on a non-empty line. The input takes a byte every cycle
// while the single group record is free; the record frees only when the
// group's final character, its fourth or a newline after it, is loaded, so no
// byte is taken while a group is being sent. Configuration writes are always
// accepted and take effect as soon as they are registered, also on a group
// already begun; write them only while the block is idle.
// Depends on b64lw_pkg, b64lw_group and b64lw_serial.
module base64_encoder_line_wrap_top import b64lw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input byte stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tlast,   // last_byte
  // Output character stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] out_char
  output logic                m_axis_tlast,   // last_char
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic       url_q, url_d;
  logic [7:0] line_len_q, line_len_d;
  grp_rec_t   rec;
  logic       rec_pop;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    url_d      = url_q;
    line_len_d = line_len_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgUrlAlphabet: url_d      = cfg_data_i[0];
        CfgLineLength:  line_len_d = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_q      <= 1'b0;
      line_len_q <= LineLenRst;
    end else begin
      url_q      <= url_d;
      line_len_q <= line_len_d;
    end
  end

  b64lw_group u_group (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .url_i      (url_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .rec_o      (rec),
    .rec_pop_i  (rec_pop)
  );

  b64lw_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_length_i (line_len_q),
    .rec_i         (rec),
    .rec_pop_o     (rec_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_char_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );

endmodule

### test/tb_top.sv
// Testbench for base64_encoder_line_wrap_top: byte stream in, wrapped Base64 text out.
// A directed table runs first, then random streams across several line settings.
// Depends on b64lw_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import b64lw_pkg::*;

  localparam int unsigned DrainCycles = 16;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DirRows     = 23;
  localparam string StdAlpha =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam string UrlAlpha =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {SINK_FLOW, SINK_COIN, SINK_QUARTER, SINK_MOSTLY} sink_mode_e;

  // One directed row; txt holds the text read straight off the encoding, 0 if none
  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [7:0]          val;
    logic                lst;
    logic [63:0]         txt;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } char_rec_t;

  localparam dir_row_t DirTab [DirRows] = '{
    '{ROW_BYTE, '0, 8'h00, 1'b1, "AA==\n"},
    '{ROW_BYTE, '0, 8'hFF, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'hFF, 1'b1, "//8=\n"},
    '{ROW_BYTE, '0, 8'hFF, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'hFF, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'hFF, 1'b1, "////\n"},
    '{ROW_BYTE, '0, 8'hFB, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'hEF, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'hBE, 1'b0, "++++"},
    '{ROW_CFG, CfgUrlAlphabet, 8'd1, 1'b0, 64'h0},
    // line shortened while four characters already sit on it
    '{ROW_CFG, CfgLineLength, 8'd1, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'hFF, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'hFF, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'hFF, 1'b0, "_\n_\n_\n_\n"},
    '{ROW_BYTE, '0, 8'hF8, 1'b1, "-\nA\n=\n=\n"},
    // zero line length means 256 characters
    '{ROW_CFG, CfgLineLength, 8'd0, 1'b0, 64'h0},
    '{ROW_CFG, CfgUrlAlphabet, 8'd0, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'h00, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'h10, 1'b1, 64'h0},
    '{ROW_CFG, CfgLineLength, 8'd255, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'h14, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'hFB, 1'b0, 64'h0},
    '{ROW_BYTE, '0, 8'h9C, 1'b1, 64'h0}
  };

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata   = 8'h00;
  logic                s_axis_tlast   = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;

  // Encoder mirror: configuration and running state
  logic        enc_url      = 1'b0;
  logic [7:0]  enc_line_len = LineLenRst;
  logic [15:0] enc_held     = 16'h0000;
  int unsigned enc_fill     = 0;
  logic [7:0]  enc_col      = 8'd0;

  char_rec_t   group_chars[$];   // characters caused by the latest byte
  char_rec_t   b64_out_q[$];     // characters still owed by the block
  char_rec_t   due_char;
  int unsigned mismatch_cnt   = 0;
  int unsigned burst_left     = 0;
  int unsigned sink_hold_req  = 0;
  int unsigned sink_hold_done = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  base64_encoder_line_wrap_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  task automatic flag_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic logic [7:0] sextet_ascii(input logic [5:0] v);
    return enc_url ? UrlAlpha[v] : StdAlpha[v];
  endfunction

  // Append one character, then a newline when the line is full
  function automatic void emit_encoded(input logic [7:0] c);
    int unsigned lim;
    int unsigned n;
    lim = (enc_line_len == 8'd0) ? 256 : int'(enc_line_len);
    n   = int'(enc_col) + 1;
    group_chars.push_back('{ch: c, lst: 1'b0});
    if (n >= lim) begin
      group_chars.push_back('{ch: NewlineChar, lst: 1'b0});
      enc_col = 8'd0;
    end else begin
      enc_col = n[7:0];
    end
  endfunction

  // Work out the characters one accepted byte causes
  function automatic void encode_byte(input logic [7:0] b, input logic lst);
    int unsigned nb;
    logic [23:0] grp;
    group_chars.delete();
    if (enc_fill == 0) begin
      enc_held = {b, 8'h00};
    end else if (enc_fill == 1) begin
      enc_held[7:0] = b;
    end
    nb = enc_fill + 1;
    // short group still open: hold only
    if (nb < 3 && !lst) begin
      enc_fill = nb;
      return;
    end
    grp = {enc_held, (nb == 3) ? b : 8'h00};
    emit_encoded(sextet_ascii(grp[23:18]));
    emit_encoded(sextet_ascii(grp[17:12]));
    emit_encoded((nb >= 2) ? sextet_ascii(grp[11:6]) : PadChar);
    emit_encoded((nb >= 3) ? sextet_ascii(grp[5:0]) : PadChar);
    enc_fill = 0;
    enc_held = 16'h0000;
    // closing newline at end of stream unless the line is empty
    if (lst && enc_col != 8'd0) begin
      group_chars.push_back('{ch: NewlineChar, lst: 1'b0});
      enc_col = 8'd0;
    end
    group_chars[group_chars.size()-1].lst = 1'b1;
  endfunction

  // Offer one byte in bursts with random gaps; predict on transfer
  task automatic send_byte(input logic [7:0] d, input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    encode_byte(d, lst);
    foreach (group_chars[j]) b64_out_q.push_back(group_chars[j]);
  endtask

  // Stop offering, let every owed character out, then allow the pipe to settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (b64_out_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgUrlAlphabet: enc_url      = val[0];
      CfgLineLength:  enc_line_len = val;
      default: ;
    endcase
  endtask

  // Output check on every character transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (b64_out_q.size() == 0) begin
        flag_mismatch($sformatf("char %02h with nothing owed", m_axis_tdata));
      end else begin
        due_char = b64_out_q.pop_front();
        if (m_axis_tdata !== due_char.ch)
          flag_mismatch($sformatf("out_char %02h, wanted %02h", m_axis_tdata, due_char.ch));
        if (m_axis_tlast !== due_char.lst)
          flag_mismatch($sformatf("last_char %b, wanted %b on char %02h",
                                  m_axis_tlast, due_char.lst, due_char.ch));
      end
    end
  end

  // Receiver: changing stall pattern, plus a long hold-off on request
  initial begin : sink_proc
    sink_mode_e  mode;
    int unsigned cyc;
    mode = SINK_FLOW;
    cyc  = 0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req != sink_hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        sink_hold_done++;
      end else begin
        if (cyc % 48 == 0) mode = sink_mode_e'($urandom_range(0, 3));
        cyc++;
        case (mode)
          SINK_FLOW:    m_axis_tready <= 1'b1;
          SINK_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
          SINK_QUARTER: m_axis_tready <= (cyc % 4 == 0);
          default:      m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Run limit
  initial begin : watchdog
    #2_000_000;
    $display("FAIL base64_encoder_line_wrap_top");
    $finish;
  end

  initial begin : stim_proc
    logic [7:0]  typed[$];
    logic [7:0]  len;
    logic [7:0]  b;
    int          k;
    int unsigned budget;
    int unsigned sent;
    int unsigned slen;
    bit          open;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed table
    for (int r = 0; r < DirRows; r++) begin
      if (DirTab[r].kind == ROW_CFG) begin
        write_reg(DirTab[r].idx, DirTab[r].val);
      end else begin
        send_byte(DirTab[r].val, DirTab[r].lst);
        if (DirTab[r].txt != 64'h0) begin
          typed.delete();
          for (k = 7; k >= 0; k--)
            if (DirTab[r].txt[k*8 +: 8] != 8'h00) typed.push_back(DirTab[r].txt[k*8 +: 8]);
          if (typed.size() != group_chars.size()) begin
            flag_mismatch($sformatf("row %0d: %0d chars predicted, %0d in table",
                                    r, group_chars.size(), typed.size()));
          end else begin
            foreach (typed[j])
              if (typed[j] != group_chars[j].ch)
                flag_mismatch($sformatf("row %0d: char %0d differs from table", r, j));
          end
        end
      end
    end

    // Random streams over several line settings; some streams stay open
    // across a setting change, so a group may straddle an alphabet switch
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(CfgUrlAlphabet, 8'($urandom_range(0, 1)));
      case (ph)
        0:       len = 8'd1;
        1:       len = 8'd0;
        2:       len = 8'd255;
        3:       len = 8'd2;
        default: len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                   : 8'($urandom_range(1, 12));
      endcase
      write_reg(CfgLineLength, len);
      if (ph == 3) sink_hold_req++;
      // a zero line length gets one stream long enough to wrap
      budget = (len == 8'd0) ? 195 : 10;
      sent   = 0;
      while (sent < budget) begin
        slen = (budget > 100) ? budget : $urandom_range(1, 12);
        open = (budget < 100) && ($urandom_range(0, 5) == 0);
        for (int i = 0; i < slen; i++) begin
          b = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                          : 8'($urandom_range(0, 255));
          send_byte(b, (i == slen - 1) && !open);
        end
        sent += slen;
      end
    end

    wait_idle();
    if (mismatch_cnt == 0 && b64_out_q.size() == 0) begin
      $display("PASS base64_encoder_line_wrap_top");
    end else begin
      $display("FAIL base64_encoder_line_wrap_top");
    end
    $finish;
  end

endmodule
